// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
// Every macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge.
`define RSG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define RSG_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define RSG_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rsg_pkg.sv =====
package rsg_pkg;

  // Field and port widths.
  localparam int FIELD_W   = 12;
  localparam int IN_W      = 2 * FIELD_W;
  localparam int CHAN_W    = 8;
  localparam int OUT_W     = 3 * CHAN_W;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

  // Size limits and reset values.
  localparam logic [CFG_W-1:0] SIZE_MIN   = 13'd1;
  localparam logic [CFG_W-1:0] SIZE_MAX   = 13'd4096;
  localparam logic [CFG_W-1:0] RST_WIDTH  = 13'd800;
  localparam logic [CFG_W-1:0] RST_HEIGHT = 13'd400;

  // The blue channel does not blend; it is always at full intensity.
  localparam logic [CHAN_W-1:0] BLUE_FULL = 8'hFF;

  // Force a written image size into the legal range.
  function automatic logic [CFG_W-1:0] fix_size(input logic [CFG_W-1:0] s);
    logic [CFG_W-1:0] r;
    if (s == '0) begin
      r = SIZE_MIN;
    end else if (s > SIZE_MAX) begin
      r = SIZE_MAX;
    end else begin
      r = s;
    end
    return r;
  endfunction

endpackage

// ===== rtl/rsg_div_step.sv =====
module rsg_div_step #(
  parameter int W = 13
) (
  input  logic [W-1:0] rem,
  input  logic [W-1:0] dvs,
  input  logic         bit_in,
  output logic [W-1:0] rem_nxt,
  output logic         q
);

  logic [W:0] sh;
  logic [W:0] diff;

  // One restoring division step: shift in a dividend bit, subtract if it fits.
  always_comb begin
    sh      = {rem, bit_in};
    diff    = sh - {1'b0, dvs};
    q       = (sh >= {1'b0, dvs});
    rem_nxt = q ? diff[W-1:0] : sh[W-1:0];
  end

endmodule

// ===== rtl/rsg_sqrt_step.sv =====
module rsg_sqrt_step #(
  parameter int QW = 18
) (
  input  logic [QW+1:0] rem,
  input  logic [QW-1:0] root,
  input  logic [1:0]    bits,
  output logic [QW+1:0] rem_nxt,
  output logic [QW-1:0] root_nxt
);

  localparam int RW = QW + 2;

  logic [RW-1:0] sh;
  logic [RW-1:0] trial;
  logic          ge;

  // One digit of the integer square root: bring down two bits, try 4*root+1.
  always_comb begin
    sh       = {rem[RW-3:0], bits};
    trial    = {root, 2'b01};
    ge       = (sh >= trial);
    rem_nxt  = ge ? (sh - trial) : sh;
    root_nxt = {root[QW-2:0], ge};
  end

endmodule

// ===== rtl/ray_sky_gradient_shader_unit.sv =====
// Sky gradient shader: each request carries one pixel (column, row from the bottom)
// and yields one 8-bit red, green, blue color of the sky seen along the camera ray
// through that pixel. The pipeline takes one pixel every clock unless the output stalls;
// its stages are the two bit-per-stage coordinate dividers, the digit-per-stage square
// root and the bit-per-stage normalizing divider. A stall at the output freezes the whole
// pipeline and holds in_tready low. Image width and height are written through the
// cfg port (index 0 and 1), clamped to 1..4096, and should change only while idle.
`include "assert_macros.svh"

module ray_sky_gradient_shader_unit #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // Fields from bit 0: pixel_column[11:0], pixel_row[11:0].
  input  logic [rsg_pkg::IN_W-1:0]           in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // Fields from bit 0: red[7:0], green[7:0], blue[7:0].
  output logic [rsg_pkg::OUT_W-1:0]          out_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rsg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rsg_pkg::CFG_W-1:0]          cfg_data
);

  import rsg_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int SQN = F + 2;
  localparam int LW  = F + 2;
  localparam int L2W = 2 * F + 4;
  localparam int CB  = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;

  localparam longint unsigned ONE_L  = 64'd1 << F;
  localparam longint unsigned K_L    = (64'd25599 * ONE_L + 64'd50) / 64'd100;
  localparam longint unsigned CSEV_L = (64'd7 * ONE_L + 64'd5) / 64'd10;
  localparam longint unsigned CG_L   = ONE_L - CSEV_L;

  localparam logic [F:0]       ONE   = {1'b1, {F{1'b0}}};
  localparam logic [F+7:0]     K     = K_L[F+7:0];
  localparam logic [F-1:0]     CG    = CG_L[F-1:0];
  localparam logic [FIELD_W-1:0] CMASK = {FIELD_W{1'b1}} >> (FIELD_W - CB);

  // Pipeline advance: everything moves unless a finished result is held.
  logic ce;
  assign ce        = !out_tvalid || out_tready;
  assign in_tready = ce;
  assign cfg_ready = 1'b1;

  // Configuration registers, stored already clamped.
  logic [CFG_W-1:0] w_r;
  logic [CFG_W-1:0] h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= RST_WIDTH;
      h_r <= RST_HEIGHT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WIDTH:  w_r <= fix_size(cfg_data);
        REG_HEIGHT: h_r <= fix_size(cfg_data);
        default: ;
      endcase
    end
  end

  // Coordinate masking and clamping below the image size.
  logic [FIELD_W-1:0] x_m;
  logic [FIELD_W-1:0] y_m;
  logic [FIELD_W-1:0] x_c;
  logic [FIELD_W-1:0] y_c;
  logic [CFG_W-1:0]   w_m1;
  logic [CFG_W-1:0]   h_m1;

  always_comb begin
    x_m  = in_tdata[FIELD_W-1:0] & CMASK;
    y_m  = in_tdata[IN_W-1:FIELD_W] & CMASK;
    w_m1 = w_r - 13'd1;
    h_m1 = h_r - 13'd1;
    x_c  = ({1'b0, x_m} >= w_r) ? w_m1[FIELD_W-1:0] : x_m;
    y_c  = ({1'b0, y_m} >= h_r) ? h_m1[FIELD_W-1:0] : y_m;
  end

  // Coordinate dividers: u = x*ONE/w and v = y*ONE/h, one quotient bit a stage.
  logic [CFG_W-1:0] rx_r [0:F];
  logic [CFG_W-1:0] ry_r [0:F];
  logic [CFG_W-1:0] dw_r [0:F];
  logic [CFG_W-1:0] dh_r [0:F];
  logic [F-1:0]     qx_r [0:F];
  logic [F-1:0]     qy_r [0:F];
  logic             vd_r [0:F];

  always_ff @(posedge clk) begin
    if (ce) begin
      rx_r[0] <= {1'b0, x_c};
      ry_r[0] <= {1'b0, y_c};
      dw_r[0] <= w_r;
      dh_r[0] <= h_r;
      qx_r[0] <= '0;
      qy_r[0] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r[0] <= 1'b0;
    end else if (ce) begin
      vd_r[0] <= in_tvalid;
    end
  end

  for (genvar i = 1; i <= F; i++) begin : g_div1
    logic [CFG_W-1:0] rx_nxt;
    logic [CFG_W-1:0] ry_nxt;
    logic             qxb;
    logic             qyb;

    rsg_div_step #(.W(CFG_W)) u_dx (
      .rem(rx_r[i-1]), .dvs(dw_r[i-1]), .bit_in(1'b0), .rem_nxt(rx_nxt), .q(qxb)
    );
    rsg_div_step #(.W(CFG_W)) u_dy (
      .rem(ry_r[i-1]), .dvs(dh_r[i-1]), .bit_in(1'b0), .rem_nxt(ry_nxt), .q(qyb)
    );

    always_ff @(posedge clk) begin
      if (ce) begin
        rx_r[i] <= rx_nxt;
        ry_r[i] <= ry_nxt;
        dw_r[i] <= dw_r[i-1];
        dh_r[i] <= dh_r[i-1];
        qx_r[i] <= {qx_r[i-1][F-2:0], qxb};
        qy_r[i] <= {qy_r[i-1][F-2:0], qyb};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vd_r[i] <= 1'b0;
      end else if (ce) begin
        vd_r[i] <= vd_r[i-1];
      end
    end
  end

  // Ray direction: dx = 4u - 2, dy = 2v - 1.
  logic signed [F+2:0] dx_r;
  logic signed [F+1:0] dy_r;
  logic                vb_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      dx_r <= $signed({1'b0, qx_r[F], 2'b00}) - $signed({2'b01, {(F+1){1'b0}}});
      dy_r <= $signed({1'b0, qy_r[F], 1'b0}) - $signed({2'b01, {F{1'b0}}});
    end
  end

  // Squares of the direction components.
  logic signed [2*F+5:0] sqx_full;
  logic signed [2*F+3:0] sqy_full;
  logic [2*F+2:0]        sqx_r;
  logic [2*F:0]          sqy_r;
  logic signed [F+1:0]   dyc_r;
  logic                  vc_r;

  assign sqx_full = $signed({{(F+3){dx_r[F+2]}}, dx_r}) * $signed({{(F+3){dx_r[F+2]}}, dx_r});
  assign sqy_full = $signed({{(F+2){dy_r[F+1]}}, dy_r}) * $signed({{(F+2){dy_r[F+1]}}, dy_r});

  always_ff @(posedge clk) begin
    if (ce) begin
      sqx_r <= sqx_full[2*F+2:0];
      sqy_r <= sqy_full[2*F:0];
      dyc_r <= dy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (ce) begin
      vb_r <= vd_r[F];
      vc_r <= vb_r;
    end
  end

  // Square root of the squared length, two radicand bits a stage.
  logic [L2W-1:0] l2_r    [0:SQN];
  logic [LW+1:0]  srem_r  [0:SQN];
  logic [LW-1:0]  sroot_r [0:SQN];
  logic [F:0]     sady_r  [0:SQN];
  logic           sneg_r  [0:SQN];
  logic           sv_r    [0:SQN];
  logic [F+1:0]   dy_abs;

  assign dy_abs = dyc_r[F+1] ? (-dyc_r) : dyc_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      l2_r[0]    <= {1'b0, sqx_r} + {3'b0, sqy_r} + {4'b0001, {(2*F){1'b0}}};
      srem_r[0]  <= '0;
      sroot_r[0] <= '0;
      sady_r[0]  <= dy_abs[F:0];
      sneg_r[0]  <= dyc_r[F+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r[0] <= 1'b0;
    end else if (ce) begin
      sv_r[0] <= vc_r;
    end
  end

  for (genvar k = 1; k <= SQN; k++) begin : g_sqrt
    logic [LW+1:0] rem_nxt;
    logic [LW-1:0] root_nxt;

    rsg_sqrt_step #(.QW(LW)) u_step (
      .rem(srem_r[k-1]),
      .root(sroot_r[k-1]),
      .bits(l2_r[k-1][L2W-1-2*(k-1) -: 2]),
      .rem_nxt(rem_nxt),
      .root_nxt(root_nxt)
    );

    always_ff @(posedge clk) begin
      if (ce) begin
        l2_r[k]    <= l2_r[k-1];
        srem_r[k]  <= rem_nxt;
        sroot_r[k] <= root_nxt;
        sady_r[k]  <= sady_r[k-1];
        sneg_r[k]  <= sneg_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[k] <= 1'b0;
      end else if (ce) begin
        sv_r[k] <= sv_r[k-1];
      end
    end
  end

  // Normalizing divider: |uy| = |dy|*ONE/len, one quotient bit a stage.
  logic [LW-1:0] r2_r [0:F];
  logic [LW-1:0] dl_r [0:F];
  logic [F-1:0]  q2_r [0:F];
  logic          n2_r [0:F];
  logic          v2_r [0:F];

  always_ff @(posedge clk) begin
    if (ce) begin
      r2_r[0] <= {1'b0, sady_r[SQN]};
      dl_r[0] <= sroot_r[SQN];
      q2_r[0] <= '0;
      n2_r[0] <= sneg_r[SQN];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r[0] <= 1'b0;
    end else if (ce) begin
      v2_r[0] <= sv_r[SQN];
    end
  end

  for (genvar j = 1; j <= F; j++) begin : g_div2
    logic [LW-1:0] rem_nxt;
    logic          qb;

    rsg_div_step #(.W(LW)) u_step (
      .rem(r2_r[j-1]), .dvs(dl_r[j-1]), .bit_in(1'b0), .rem_nxt(rem_nxt), .q(qb)
    );

    always_ff @(posedge clk) begin
      if (ce) begin
        r2_r[j] <= rem_nxt;
        dl_r[j] <= dl_r[j-1];
        q2_r[j] <= {q2_r[j-1][F-2:0], qb};
        n2_r[j] <= n2_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v2_r[j] <= 1'b0;
      end else if (ce) begin
        v2_r[j] <= v2_r[j-1];
      end
    end
  end

  // Blend factor t = (uy + 1)/2, red directly and the green product.
  logic [F:0]     tsum;
  logic [F-1:0]   t_val;
  logic [F:0]     r_r;
  logic [2*F-1:0] gp_r;
  logic           vt_r;

  always_comb begin
    tsum  = n2_r[F] ? (ONE - {1'b0, q2_r[F]}) : (ONE + {1'b0, q2_r[F]});
    t_val = tsum[F:1];
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      r_r  <= ONE - {2'b00, t_val[F-1:1]};
      gp_r <= {{F{1'b0}}, t_val} * {{F{1'b0}}, CG};
    end
  end

  // Channel intensities in fixed point.
  logic [F:0] rch_r;
  logic [F:0] gch_r;
  logic       vg_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      rch_r <= r_r;
      gch_r <= ONE - {1'b0, gp_r[2*F-1:F]};
    end
  end

  // Scale to 8-bit range.
  logic [2*F+8:0] kr_r;
  logic [2*F+8:0] kg_r;
  logic           vp_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      kr_r <= {{(F+1){1'b0}}, K} * {8'd0, rch_r};
      kg_r <= {{(F+1){1'b0}}, K} * {8'd0, gch_r};
    end
  end

  // Output register with saturation.
  logic [8:0]        rb;
  logic [8:0]        gb;
  logic [OUT_W-1:0]  out_tdata_r;
  logic              out_tvalid_r;

  always_comb begin
    rb = kr_r[2*F+8:2*F];
    gb = kg_r[2*F+8:2*F];
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_tdata_r <= {BLUE_FULL,
                      (gb[8] ? 8'hFF : gb[7:0]),
                      (rb[8] ? 8'hFF : rb[7:0])};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vt_r         <= 1'b0;
      vg_r         <= 1'b0;
      vp_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else if (ce) begin
      vt_r         <= v2_r[F];
      vg_r         <= vt_r;
      vp_r         <= vg_r;
      out_tvalid_r <= vp_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Checks on the datapath and the size registers.
  `RSG_ASSERT(a_size_legal, (w_r != 13'd0) && (w_r <= SIZE_MAX) && (h_r != 13'd0) && (h_r <= SIZE_MAX), "image size out of range")
  `RSG_IMPLY(a_blue_full, out_tvalid, out_tdata[OUT_W-1:2*CHAN_W] == BLUE_FULL, "blue not full")
  `RSG_IMPLY(a_green_ge_red, out_tvalid, out_tdata[2*CHAN_W-1:CHAN_W] >= out_tdata[CHAN_W-1:0], "green below red")
  `RSG_NEXT(a_accept_enters, in_tvalid && in_tready, vd_r[0], "accepted pixel did not enter the pipeline")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import rsg_pkg::*;

  localparam int FRAC = 16;
  localparam int LATENCY = 3 * FRAC + 11;
  localparam longint ONE = 64'd1 << FRAC;

  // Field order matches out_tdata: red in the lowest byte.
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } sky_color_t;

  // Sky color model: tracks the image size and predicts the color of each pixel.
  class sky_scoreboard;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    sky_color_t pending_colors[$];
    int mismatches;

    function void reset_size();
      width_reg = RST_WIDTH;
      height_reg = RST_HEIGHT;
    endfunction

    function void write_size(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == REG_WIDTH) begin
        width_reg = val;
      end else if (idx == REG_HEIGHT) begin
        height_reg = val;
      end
    endfunction

    function longint clamp_size(logic [CFG_W-1:0] s);
      if (s == 0) return 1;
      if (s > 4096) return 4096;
      return s;
    endfunction

    function longint int_sqrt(longint unsigned n);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
        if (n >= root + bitv) begin
          n -= root + bitv;
          root = (root >> 1) + bitv;
        end else begin
          root >>= 1;
        end
        bitv >>= 2;
      end
      return root;
    endfunction

    function logic [7:0] scale_byte(longint chan);
      longint k, v;
      k = (25599 * ONE + 50) / 100;
      v = (k * chan) >>> (2 * FRAC);
      return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    // Predict the color for one accepted pixel request.
    function void note_pixel(logic [11:0] col, logic [11:0] row);
      longint w, h, x, y, u, v, dx, dy, len, ady, mag, uy, t, seven;
      sky_color_t c;
      w = clamp_size(width_reg);
      h = clamp_size(height_reg);
      x = col;
      y = row;
      if (x >= w) x = w - 1;
      if (y >= h) y = h - 1;
      u = (x << FRAC) / w;
      v = (y << FRAC) / h;
      dx = 4 * u - 2 * ONE;
      dy = 2 * v - ONE;
      len = int_sqrt(dx * dx + dy * dy + ONE * ONE);
      if (len == 0) len = 1;
      ady = (dy < 0) ? -dy : dy;
      mag = (ady << FRAC) / len;
      if (mag > ONE) mag = ONE;
      uy = (dy < 0) ? -mag : mag;
      t = (uy + ONE) >>> 1;
      seven = (7 * ONE + 5) / 10;
      c.red = scale_byte(ONE - ((t * (ONE - ONE / 2)) >>> FRAC));
      c.green = scale_byte(ONE - ((t * (ONE - seven)) >>> FRAC));
      c.blue = scale_byte(ONE);
      pending_colors.push_back(c);
    endfunction

    function void check_color(sky_color_t got);
      sky_color_t exp_c;
      if (pending_colors.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected color %h", got);
        return;
      end
      exp_c = pending_colors.pop_front();
      if (got.red !== exp_c.red || got.green !== exp_c.green || got.blue !== exp_c.blue) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Color mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                   exp_c.red, exp_c.green, exp_c.blue, got.red, got.green, got.blue);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  sky_scoreboard sky_model = new();
  int hold_off_cycles = 0;

  always #1 clk = ~clk;

  ray_sky_gradient_shader_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Accepted pixels feed the model; accepted colors are checked.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sky_model.note_pixel(in_tdata[11:0], in_tdata[23:12]);
    if (rst_n && out_tvalid && out_tready) sky_model.check_color(out_tdata);
  end

  // Receiver stalls on its own pattern, with a long hold-off when a test sets one.
  initial begin
    int phase;
    phase = 0;
    forever begin
      @(negedge clk);
      phase++;
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        out_tready <= 1'b0;
      end else if ((phase / 200) % 3 == 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Write one register, then leave the channel idle before returning.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sky_model.write_size(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Send one pixel request; valid stays high across back-to-back sends.
  task automatic send_pixel(logic [11:0] col, logic [11:0] row);
    in_tdata <= {row, col};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sky_model.pending_colors.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  // Random pixels in bursts; mostly inside the image, some clamped, some full range.
  task automatic random_pixels(int count);
    int sent, burst;
    logic [11:0] col, row;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 20);
      while (burst > 0 && sent < count) begin
        case ($urandom_range(0, 9))
          0: begin
            col = 12'($urandom);
            row = 12'($urandom);
          end
          1: begin
            col = 12'(sky_model.clamp_size(sky_model.width_reg) - 1);
            row = 12'($urandom_range(0, 4095));
          end
          default: begin
            col = 12'($urandom_range(0, sky_model.clamp_size(sky_model.width_reg) - 1));
            row = 12'($urandom_range(0, sky_model.clamp_size(sky_model.height_reg) - 1));
          end
        endcase
        send_pixel(col, row);
        burst--;
        sent++;
      end
      if ($urandom_range(0, 2) == 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  endtask

  initial begin
    sky_model.mismatches = 0;
    sky_model.reset_size();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: corners, field extremes and clamping at reset size.
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd799, 12'd399);
    send_pixel(12'd400, 12'd200);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'd800, 12'd400);
    send_pixel(12'hAAA, 12'h555);
    send_pixel(12'h555, 12'hAAA);
    send_pixel(12'd0, 12'd399);
    drain();

    // Zero size is treated as one.
    write_reg(REG_WIDTH, 13'd0);
    write_reg(REG_HEIGHT, 13'd0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'hFFF, 12'hFFF);
    drain();

    // Oversized size saturates at the maximum.
    write_reg(REG_WIDTH, 13'h1FFF);
    write_reg(REG_HEIGHT, 13'd4097);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'd0, 12'hFFF);
    send_pixel(12'd2048, 12'd2048);
    drain();

    write_reg(REG_WIDTH, 13'd4096);
    write_reg(REG_HEIGHT, 13'd1);
    send_pixel(12'hFFF, 12'd7);
    send_pixel(12'd1, 12'd0);
    drain();

    // Long receiver hold-off while the sender keeps offering pixels.
    write_reg(REG_WIDTH, RST_WIDTH);
    write_reg(REG_HEIGHT, RST_HEIGHT);
    hold_off_cycles = 300;
    random_pixels(120);
    drain();

    write_reg(REG_WIDTH, 13'd17);
    write_reg(REG_HEIGHT, 13'd4096);
    random_pixels(150);
    drain();

    write_reg(REG_WIDTH, 13'd1);
    write_reg(REG_HEIGHT, 13'd3000);
    random_pixels(80);
    drain();

    write_reg(REG_WIDTH, 13'($urandom_range(1, 4096)));
    write_reg(REG_HEIGHT, 13'($urandom_range(1, 4096)));
    random_pixels(150);
    drain();

    write_reg(REG_WIDTH, 13'd640);
    write_reg(REG_HEIGHT, 13'd480);
    random_pixels(130);
    drain();

    if (sky_model.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
